// ===== src/flash_page_write_assembler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Flash page write assembler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef FLASH_PAGE_WRITE_ASSEMBLER_TOP_DEFINES_SVH
`define FLASH_PAGE_WRITE_ASSEMBLER_TOP_DEFINES_SVH

// Same-cycle implication
`define FPWA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FPWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fpwa_pkg.sv =====
// ----------------------------------------------------------------------------
// Flash page write assembler package
// Field widths, status codes, register indexes and the result beat type.
// ----------------------------------------------------------------------------
package fpwa_pkg;

  localparam int ADDR_W   = 18;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  // tdata: write_addr, write_word, status, zero pad to whole bytes
  localparam int TDATA_RAW_W = ADDR_W + WORD_W + STATUS_W;
  localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;
  localparam int TPAD_W      = TDATA_W - TDATA_RAW_W;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_PAGE_WR   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_COMPLETE  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_ARMED = 3'd3;
  localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_SHORT     = 3'd5;

  // Configuration register indexes
  localparam logic REG_SLOT_SELECT = 1'b0;
  localparam logic REG_IMAGE_SIZE  = 1'b1;

  typedef struct packed {
    logic                is_write;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [STATUS_W-1:0] status;
    logic                eor;
  } result_t;

endpackage

// ===== src/flash_page_write_assembler_top.sv =====
// ----------------------------------------------------------------------------
// Flash page write assembler
// Packs image bytes into a page memory and emits full or final pages as
// little-endian 32-bit flash word writes.
// ----------------------------------------------------------------------------
// Usage:
//   Configure through cfg_we/cfg_index/cfg_data while the block is idle:
//   index 0 picks the slot base, index 1 sets the image size. Any write
//   restarts the writer and arms it when the size is nonzero and fits a slot.
//   Image bytes enter on s_axis (tdata = byte, tlast = final byte), one beat
//   per byte. Each byte yields one or more m_axis beats; tlast marks the last
//   beat of a byte's run and carries its outcome in the status field.
//   A byte that does not close a page shows its beat in the cycle after
//   acceptance, and the next byte may enter then if m_axis takes the beat.
//   A byte that closes a page (or finishes the image) starts a flush: the
//   page memory is read one word per cycle while m_axis is not stalled,
//   through a registered read, giving (PAGE_BYTES+3)/4 write beats; s_axis
//   is held off until the last word beat is loaded.
//   A stalled m_axis holds the current beat; the flush read and s_axis
//   acceptance wait until the output register frees up.
//   Reset clears the counters, disarms the writer and selects slot A; the
//   page memory needs no clearing since unfilled bytes read as 0xFF.
// ----------------------------------------------------------------------------
module flash_page_write_assembler_top #(
  parameter int PAGE_BYTES   = 64,
  parameter int SLOT_BYTES   = 131072,
  parameter int SLOT_A_START = 8192,
  parameter int SLOT_B_START = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fpwa_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // last
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [17:0] write_addr, [49:18] write_word, [52:50] status, [55:53] zero
  output logic [fpwa_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,  // is_write
  output logic                          m_axis_tlast,  // end_of_run
  // Configuration write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fpwa_pkg::ADDR_W-1:0]   cfg_data
);

  localparam int AW     = fpwa_pkg::ADDR_W;
  localparam int WORDS  = (PAGE_BYTES + 3) / 4;
  localparam int WIDX   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RCNT_W = $clog2(WORDS + 1);
  localparam int FILL_W = $clog2(PAGE_BYTES + 1);
  localparam int CMP_W  = WIDX + FILL_W + 2;

  localparam logic [AW-1:0]     SLOT_A_BASE = AW'(SLOT_A_START);
  localparam logic [AW-1:0]     SLOT_B_BASE = AW'(SLOT_B_START);
  localparam logic [AW:0]       SLOT_LIMIT  = (AW + 1)'(SLOT_BYTES);
  localparam logic [AW-1:0]     PAGE_STEP   = AW'(PAGE_BYTES);
  localparam logic [FILL_W-1:0] PAGE_FULL   = FILL_W'(PAGE_BYTES);
  localparam logic [RCNT_W-1:0] WORD_COUNT  = RCNT_W'(WORDS);
  localparam logic [WIDX-1:0]   WORD_LAST   = WIDX'(WORDS - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  // Control and state registers
  logic                            state;
  logic                            slot_select;
  logic [AW-1:0]                   image_size;
  logic                            armed;
  logic [AW-1:0]                   bytes_done;
  logic [AW-1:0]                   page_address;
  logic [FILL_W-1:0]               fill;
  logic [RCNT_W-1:0]               rd_cnt;
  logic [WIDX-1:0]                 wr_idx;
  logic                            rd_valid;
  logic [fpwa_pkg::WORD_W-1:0]     rd_data;
  logic [fpwa_pkg::STATUS_W-1:0]   flush_status;
  logic                            out_valid;
  fpwa_pkg::result_t               out_res;

  // Page memory, one 32-bit word per row with byte lanes
  logic [3:0][fpwa_pkg::BYTE_W-1:0] page_mem [WORDS];

  logic                            out_free;
  logic                            in_fire;
  logic [AW:0]                     done_inc;
  logic                            overflow;
  logic [FILL_W-1:0]               fill_inc;
  logic                            page_full;
  logic                            finish;
  logic                            byte_ok;
  logic                            need_flush;
  logic [fpwa_pkg::STATUS_W-1:0]   in_status;
  logic                            rd_issue;
  logic                            rd_take;
  logic                            wr_last;
  logic [WIDX-1:0]                 mem_waddr;
  logic [fpwa_pkg::WORD_W-1:0]     flush_word;
  logic [AW-1:0]                   flush_addr;
  logic [AW-1:0]                   cfg_size;
  logic                            cfg_slot;

  // Accept a byte only when idle and the output register can take a beat
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Decode the incoming byte
  assign done_inc   = {1'b0, bytes_done} + (AW + 1)'(1);
  assign overflow   = done_inc > {1'b0, image_size};
  assign fill_inc   = fill + FILL_W'(1);
  assign page_full  = (fill_inc == PAGE_FULL);
  assign finish     = s_axis_tlast && (done_inc[AW-1:0] == image_size);
  assign byte_ok    = in_fire && armed && !overflow;
  assign need_flush = page_full || finish;
  assign mem_waddr  = WIDX'(fill >> 2);

  always_comb begin
    if (finish) begin
      in_status = fpwa_pkg::STS_COMPLETE;
    end else if (s_axis_tlast) begin
      in_status = fpwa_pkg::STS_SHORT;
    end else if (page_full) begin
      in_status = fpwa_pkg::STS_PAGE_WR;
    end else begin
      in_status = fpwa_pkg::STS_ACCEPTED;
    end
  end

  // Flush read pipeline: issue while data slot is free or being drained
  assign rd_take  = (state == ST_FLUSH) && rd_valid && out_free;
  assign rd_issue = (state == ST_FLUSH) && (rd_cnt != WORD_COUNT) && (!rd_valid || out_free);
  assign wr_last  = (wr_idx == WORD_LAST);

  // Pad bytes past the fill level with the erased value
  always_comb begin
    logic [CMP_W-1:0] pos;
    pos = '0;
    for (int j = 0; j < 4; j++) begin
      pos = CMP_W'({wr_idx, 2'b00}) + CMP_W'(j);
      flush_word[j*8 +: 8] = (pos < CMP_W'(fill)) ? rd_data[j*8 +: 8]
                                                 : fpwa_pkg::ERASED_BYTE;
    end
  end

  assign flush_addr = page_address + AW'({wr_idx, 2'b00});

  // Configuration write values
  assign cfg_slot = (cfg_index == fpwa_pkg::REG_SLOT_SELECT) ? cfg_data[0] : slot_select;
  assign cfg_size = (cfg_index == fpwa_pkg::REG_IMAGE_SIZE)  ? cfg_data    : image_size;

  // Page memory: byte write on accept, word read during flush
  always_ff @(posedge clk) begin
    if (byte_ok) begin
      page_mem[mem_waddr][fill[1:0]] <= s_axis_tdata;
    end
    if (rd_issue) begin
      rd_data <= page_mem[rd_cnt[WIDX-1:0]];
    end
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_select  <= 1'b0;
      image_size   <= '0;
      armed        <= 1'b0;
      bytes_done   <= '0;
      page_address <= SLOT_A_BASE;
      fill         <= '0;
      rd_cnt       <= '0;
      wr_idx       <= '0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Drop a beat once taken
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            out_valid <= 1'b1;
            if (!armed) begin
              out_res <= '{is_write: 1'b0, addr: '0, word: '0,
                           status: fpwa_pkg::STS_NOT_ARMED, eor: 1'b1};
            end else if (overflow) begin
              out_res <= '{is_write: 1'b0, addr: '0, word: '0,
                           status: fpwa_pkg::STS_OVERFLOW, eor: 1'b1};
            end else begin
              bytes_done <= done_inc[AW-1:0];
              fill       <= fill_inc;
              if (finish) begin
                armed <= 1'b0;
              end
              if (need_flush) begin
                out_valid    <= 1'b0;
                state        <= ST_FLUSH;
                flush_status <= in_status;
                rd_cnt       <= '0;
                wr_idx       <= '0;
              end else begin
                out_res <= '{is_write: 1'b0, addr: '0, word: '0,
                             status: in_status, eor: 1'b1};
              end
            end
          end
        end
        ST_FLUSH: begin
          rd_valid <= rd_issue || (rd_valid && !rd_take);
          if (rd_issue) begin
            rd_cnt <= rd_cnt + RCNT_W'(1);
          end
          if (rd_take) begin
            out_valid <= 1'b1;
            out_res   <= '{is_write: 1'b1, addr: flush_addr, word: flush_word,
                           status: wr_last ? flush_status : fpwa_pkg::STS_PAGE_WR,
                           eor: wr_last};
            wr_idx    <= wr_idx + WIDX'(1);
            // Close the page after its last word
            if (wr_last) begin
              state        <= ST_IDLE;
              fill         <= '0;
              page_address <= page_address + PAGE_STEP;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Restart the writer on any register write
      if (cfg_we) begin
        slot_select  <= cfg_slot;
        image_size   <= cfg_size;
        bytes_done   <= '0;
        fill         <= '0;
        page_address <= cfg_slot ? SLOT_B_BASE : SLOT_A_BASE;
        armed        <= (cfg_size != '0) && ({1'b0, cfg_size} <= SLOT_LIMIT);
      end
    end
  end

  // Drive the result stream
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.is_write;
  assign m_axis_tlast  = out_res.eor;
  assign m_axis_tdata  = {{fpwa_pkg::TPAD_W{1'b0}}, out_res.status, out_res.word, out_res.addr};

endmodule

// ===== src/fpwa_checker.sv =====
// ----------------------------------------------------------------------------
// Flash page write assembler port checker
// Watches the result stream for run structure and write address order.
// ----------------------------------------------------------------------------
`include "flash_page_write_assembler_top_defines.svh"

module fpwa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fpwa_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  localparam int AW = fpwa_pkg::ADDR_W;

  logic [AW-1:0]                 addr;
  logic [fpwa_pkg::STATUS_W-1:0] status;
  logic                          beat;

  assign addr   = m_axis_tdata[AW-1:0];
  assign status = m_axis_tdata[AW + fpwa_pkg::WORD_W +: fpwa_pkg::STATUS_W];
  assign beat   = m_axis_tvalid && m_axis_tready;

  // A stalled beat holds its payload
  `FPWA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

  // Rejected bytes give a single non-write beat
  `FPWA_ASSERT_SAME(a_reject, m_axis_tvalid && (status == fpwa_pkg::STS_NOT_ARMED || status == fpwa_pkg::STS_OVERFLOW), !m_axis_tuser && m_axis_tlast, "reject status on a write or mid-run beat")

  // Only write beats continue a run, and they carry page writing status
  `FPWA_ASSERT_SAME(a_midrun, m_axis_tvalid && !m_axis_tlast, m_axis_tuser && (status == fpwa_pkg::STS_PAGE_WR), "mid-run beat is not a page write")

  // Words of one page follow each other at rising word addresses
  `FPWA_ASSERT_NEXT(a_addr_step, beat && m_axis_tuser && !m_axis_tlast, !m_axis_tvalid || (m_axis_tuser && (addr == AW'($past(addr) + AW'(4)))), "page word address did not advance by four")

endmodule

bind flash_page_write_assembler_top fpwa_checker u_fpwa_checker (.*);
